[design/gbba_pkg.sv]
// ----------------------------------------------------------------------------
// gbba_pkg
// Types, constants and state codes shared by the block allocator modules.
// ----------------------------------------------------------------------------
package gbba_pkg;

    localparam int unsigned GROUPS_DEF           = 8;
    localparam int unsigned BLOCKS_PER_GROUP_DEF = 256;
    localparam int unsigned BLK_W                = 12;
    localparam int unsigned GCNT_W               = 9;
    localparam logic [GCNT_W-1:0] GCNT_MAX       = '1;
    localparam logic [BLK_W-1:0]  TOTAL_MAX      = '1;

    // configuration register indexes
    localparam logic [1:0] CFG_FIRST_DATA = 2'd0;
    localparam logic [1:0] CFG_BLOCKS_CNT = 2'd1;
    localparam logic [1:0] CFG_GROUPS_USE = 2'd2;

    // request codes
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_SPACE = 2'd1;
    localparam logic [1:0] ST_BAD_FREE = 2'd2;

    typedef struct packed {
        logic             func;
        logic [BLK_W-1:0] block_number;
    } t_in_item;

    typedef struct packed {
        logic [1:0]       status;
        logic [BLK_W-1:0] result_block;
        logic [BLK_W-1:0] free_total;
    } t_out_item;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_PREP,
        S_GROUP,
        S_RDWAIT,
        S_WORD,
        S_FREE_RD,
        S_FREE_WR,
        S_OUT
    } t_state;

    // controller -> datapath commands
    typedef struct packed {
        logic clear_step;
        logic load;
        logic prep;
        logic grp_next;
        logic word_rd;
        logic word_next;
        logic alloc_wr;
        logic free_rd;
        logic free_wr;
        logic no_space;
        logic out_load;
    } t_cmd;

    // datapath -> controller status
    typedef struct packed {
        logic clear_done;
        logic is_free;
        logic free_bad;
        logic grp_done;
        logic grp_has_free;
        logic word_has_zero;
        logic word_last;
    } t_sts;

endpackage

[design/grouped_bitmap_block_allocator.sv]
// ----------------------------------------------------------------------------
// grouped_bitmap_block_allocator
// Group-based bitmap block allocator: allocate near a goal, or free a block.
//
//   channel | direction | handshake               | payload
//   in      | input     | i_in_valid/o_in_ready   | t_in_item
//   out     | output    | o_out_valid/i_out_ready | t_out_item
//   cfg     | input     | i_cfg_we                | i_cfg_index, i_cfg_wdata
//
// One item at a time. A free reads the bitmap word, writes it back and then
// loads the result. An allocate visits groups from the goal group on and
// reads each bitmap word of a group with free blocks through a registered
// read and a wait state, until a clear bit is found or every group in use
// has been visited. After reset a clearing pass zeroes the bitmap; no item
// is taken meanwhile. A held result stalls the block.
// ----------------------------------------------------------------------------
module grouped_bitmap_block_allocator #(
    parameter int unsigned GROUPS           = gbba_pkg::GROUPS_DEF,
    parameter int unsigned BLOCKS_PER_GROUP = gbba_pkg::BLOCKS_PER_GROUP_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [11:0]         i_cfg_index,
    input  logic [11:0]         i_cfg_wdata,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  gbba_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output gbba_pkg::t_out_item o_out
);
    import gbba_pkg::*;

    t_cmd cmd;
    t_sts sts;

    gbba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    gbba_dpath #(
        .GROUPS           (GROUPS),
        .BLOCKS_PER_GROUP (BLOCKS_PER_GROUP)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out       (o_out)
    );

endmodule

[design/gbba_ctrl.sv]
// ----------------------------------------------------------------------------
// gbba_ctrl
// Sequencer for the block allocator: clearing pass, group scan, word scan, free.
// ----------------------------------------------------------------------------
module gbba_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  gbba_pkg::t_sts   i_sts,
    output gbba_pkg::t_cmd   o_cmd
);
    import gbba_pkg::*;

    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:   if (i_sts.clear_done) n_state = S_IDLE;
            S_IDLE:    if (i_in_valid) n_state = S_PREP;
            S_PREP: begin
                if (i_sts.is_free) begin
                    n_state = i_sts.free_bad ? S_OUT : S_FREE_RD;
                end else begin
                    n_state = S_GROUP;
                end
            end
            S_GROUP: begin
                if (i_sts.grp_done)          n_state = S_OUT;
                else if (i_sts.grp_has_free) n_state = S_RDWAIT;
            end
            S_RDWAIT:  n_state = S_WORD;
            S_WORD: begin
                if (i_sts.word_has_zero)  n_state = S_OUT;
                else if (i_sts.word_last) n_state = S_GROUP;
                else                      n_state = S_RDWAIT;
            end
            S_FREE_RD: n_state = S_FREE_WR;
            S_FREE_WR: n_state = S_OUT;
            S_OUT:     if (i_out_ready) n_state = S_IDLE;
            default:   n_state = S_CLEAR;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_CLEAR:   o_cmd.clear_step = 1'b1;
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_PREP:    begin
                o_cmd.prep = 1'b1;
                o_cmd.out_load = i_sts.is_free && i_sts.free_bad;
            end
            S_GROUP: begin
                o_cmd.no_space = i_sts.grp_done;
                o_cmd.out_load = i_sts.grp_done;
                o_cmd.word_rd  = !i_sts.grp_done && i_sts.grp_has_free;
                o_cmd.grp_next = !i_sts.grp_done && !i_sts.grp_has_free;
            end
            S_RDWAIT:  ;
            S_WORD: begin
                o_cmd.alloc_wr  = i_sts.word_has_zero;
                o_cmd.out_load  = i_sts.word_has_zero;
                o_cmd.word_next = !i_sts.word_has_zero;
                o_cmd.grp_next  = !i_sts.word_has_zero && i_sts.word_last;
                o_cmd.word_rd   = !i_sts.word_has_zero && !i_sts.word_last;
            end
            S_FREE_RD: o_cmd.free_rd = 1'b1;
            S_FREE_WR: begin
                o_cmd.free_wr  = 1'b1;
                o_cmd.out_load = 1'b1;
            end
            S_OUT:     o_out_valid = 1'b1;
            default:   ;
        endcase
    end

endmodule

[design/gbba_dpath.sv]
// ----------------------------------------------------------------------------
// gbba_dpath
// Bitmap memory, group counts, total count and request registers.
// ----------------------------------------------------------------------------
module gbba_dpath #(
    parameter int unsigned GROUPS           = gbba_pkg::GROUPS_DEF,
    parameter int unsigned BLOCKS_PER_GROUP = gbba_pkg::BLOCKS_PER_GROUP_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [11:0]         i_cfg_index,
    input  logic [11:0]         i_cfg_wdata,
    input  gbba_pkg::t_in_item  i_in,
    input  gbba_pkg::t_cmd      i_cmd,
    output gbba_pkg::t_sts      o_sts,
    output gbba_pkg::t_out_item o_out
);
    import gbba_pkg::*;

    localparam int unsigned WPG    = BLOCKS_PER_GROUP / 32;
    localparam int unsigned WORDS  = GROUPS * WPG;
    localparam int unsigned WA_W   = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int unsigned WIG_W  = (WPG > 1) ? $clog2(WPG) : 1;
    localparam int unsigned G_W    = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int unsigned GC_W   = $clog2(GROUPS + 1);
    localparam int unsigned BPG_SH = $clog2(BLOCKS_PER_GROUP);
    localparam logic [GCNT_W-1:0] GCNT_RST =
        (BLOCKS_PER_GROUP > 511) ? GCNT_MAX : GCNT_W'(BLOCKS_PER_GROUP);
    localparam logic [BLK_W-1:0] TOTAL_RST = BLK_W'(GROUPS * BLOCKS_PER_GROUP);

    // configuration registers
    logic             r_first;
    logic [BLK_W-1:0] r_bcount;
    logic [3:0]       r_guse;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first  <= 1'b1;
            r_bcount <= 12'd2049;
            r_guse   <= 4'd8;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                12'(CFG_FIRST_DATA): r_first  <= i_cfg_wdata[0];
                12'(CFG_BLOCKS_CNT): r_bcount <= i_cfg_wdata;
                12'(CFG_GROUPS_USE): r_guse   <= i_cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    // active group count, clamped to GROUPS
    logic [GC_W-1:0] ng;
    always_comb begin
        if (32'(r_guse) > GROUPS) ng = GC_W'(GROUPS);
        else                      ng = GC_W'(r_guse);
    end

    // request registers
    logic             r_func;
    logic [BLK_W-1:0] r_blk;
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_in.func;
            r_blk  <= i_in.block_number;
        end
    end

    // goal / free offset from first data block
    logic             in_zone;
    logic [BLK_W-1:0] goal_off;
    logic [BLK_W-1:0] blk_off;
    logic [31:0]      blk_grp;
    always_comb begin
        in_zone  = (r_blk >= BLK_W'(r_first)) && (r_blk < r_bcount);
        blk_off  = r_blk - BLK_W'(r_first);
        goal_off = in_zone ? blk_off : '0;
        blk_grp  = 32'(goal_off) >> BPG_SH;
    end

    // search state
    logic [G_W-1:0]   r_g;
    logic [GC_W-1:0]  r_gvisit;
    logic [WIG_W-1:0] r_wi;
    logic [G_W-1:0]   g_next;

    always_comb begin
        if (32'(r_g) + 1 >= 32'(ng)) g_next = '0;
        else                          g_next = r_g + G_W'(1);
    end

    // group free counts and total
    logic [GCNT_W-1:0] r_gcnt [GROUPS];
    logic [BLK_W-1:0]  r_total;

    // bitmap memory with a clearing pass after reset
    logic [31:0]    mem [WORDS];
    logic [31:0]    r_rdata;
    logic [WA_W-1:0] r_clr;
    logic            r_clr_done;
    logic [WA_W-1:0] rd_addr;
    logic [WA_W-1:0] cur_addr;
    logic [WIG_W-1:0] rd_wi;
    logic [WA_W-1:0] wr_addr;
    logic [31:0]     wr_data;
    logic            wr_en;
    logic [31:0]     zmask;
    logic [4:0]      zbit;
    logic [4:0]      fbit;

    // cur_addr is the word under test; a full word moves the read on by one
    always_comb begin
        rd_wi = i_cmd.word_next ? r_wi + WIG_W'(1) : r_wi;
        if (WPG > 1) begin
            cur_addr = WA_W'(32'(r_g) * WPG + 32'(r_wi));
            rd_addr  = WA_W'(32'(r_g) * WPG + 32'(rd_wi));
        end else begin
            cur_addr = WA_W'(r_g);
            rd_addr  = WA_W'(r_g);
        end
        fbit = blk_off[4:0];
    end

    // lowest clear bit of the registered word
    always_comb begin
        zmask = ~r_rdata & (r_rdata + 32'd1);
        zbit  = '0;
        for (int k = 0; k < 32; k++) begin
            if (zmask[k]) zbit = 5'(k);
        end
    end

    logic [WA_W-1:0] f_addr;
    assign f_addr = WA_W'(32'(blk_off) >> 5);

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = cur_addr;
        wr_data = r_rdata;
        if (!r_clr_done) begin
            wr_en = 1'b1; wr_addr = r_clr; wr_data = '0;
        end else if (i_cmd.alloc_wr) begin
            wr_en = 1'b1; wr_data = r_rdata | zmask;
        end else if (i_cmd.free_wr) begin
            wr_en = 1'b1; wr_addr = f_addr;
            wr_data = r_rdata & ~(32'd1 << fbit);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        if (i_cmd.word_rd)      r_rdata <= mem[rd_addr];
        else if (i_cmd.free_rd) r_rdata <= mem[f_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= '0;
            r_clr_done <= 1'b0;
        end else if (!r_clr_done) begin
            r_clr <= r_clr + WA_W'(1);
            if (32'(r_clr) == WORDS - 1) r_clr_done <= 1'b1;
        end
    end

    // search and count updates
    logic [BLK_W-1:0] alloc_blk;
    assign alloc_blk = BLK_W'(32'(r_first) + 32'(r_g) * BLOCKS_PER_GROUP
                       + 32'(r_wi) * 32 + 32'(zbit));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < GROUPS; k++) r_gcnt[k] <= GCNT_RST;
            r_total <= TOTAL_RST;
        end else begin
            if (i_cmd.alloc_wr) begin
                r_gcnt[r_g] <= r_gcnt[r_g] - GCNT_W'(1);
                if (r_total != '0) r_total <= r_total - BLK_W'(1);
            end
            if (i_cmd.free_wr) begin
                if (r_gcnt[r_g] != GCNT_MAX) r_gcnt[r_g] <= r_gcnt[r_g] + GCNT_W'(1);
                if (r_total != TOTAL_MAX) r_total <= r_total + BLK_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_gvisit   <= '0;
            r_wi       <= '0;
            if (blk_grp >= 32'(ng)) r_g <= '0;
            else                    r_g <= G_W'(blk_grp);
        end else if (i_cmd.grp_next) begin
            r_g      <= g_next;
            r_gvisit <= r_gvisit + GC_W'(1);
            r_wi     <= '0;
        end else if (i_cmd.word_next) begin
            r_wi <= r_wi + WIG_W'(1);
        end
    end

    // status to controller
    always_comb begin
        o_sts.clear_done    = r_clr_done;
        o_sts.is_free       = (r_func == FUNC_FREE);
        o_sts.free_bad      = !in_zone || (blk_grp >= 32'(ng));
        o_sts.grp_done      = (r_gvisit >= ng);
        o_sts.grp_has_free  = (r_gcnt[r_g] != '0);
        o_sts.word_has_zero = (r_rdata != '1);
        o_sts.word_last     = (32'(r_wi) == WPG - 1);
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (i_cmd.alloc_wr) begin
                o_out.status       <= ST_OK;
                o_out.result_block <= alloc_blk;
                o_out.free_total   <= (r_total != '0) ? r_total - BLK_W'(1) : r_total;
            end else if (i_cmd.no_space) begin
                o_out.status       <= ST_NO_SPACE;
                o_out.result_block <= '0;
                o_out.free_total   <= r_total;
            end else if (i_cmd.free_wr) begin
                o_out.status       <= ST_OK;
                o_out.result_block <= '0;
                o_out.free_total   <= (r_total != TOTAL_MAX) ? r_total + BLK_W'(1) : r_total;
            end else begin
                o_out.status       <= ST_BAD_FREE;
                o_out.result_block <= '0;
                o_out.free_total   <= r_total;
            end
        end
    end

endmodule

[tb/grouped_bitmap_block_allocator_test.sv]
// ----------------------------------------------------------------------------
// grouped_bitmap_block_allocator_test
// Self-checking bench for the block allocator: directed and random allocate
// and free requests under several volume settings, with random idling on
// both channels, and every result compared against a local model of the
// bitmap and the free counts.
// ----------------------------------------------------------------------------
module grouped_bitmap_block_allocator_test;
    import gbba_pkg::*;

    localparam int unsigned NGRP  = GROUPS_DEF;
    localparam int unsigned BPG   = BLOCKS_PER_GROUP_DEF;
    localparam int unsigned NBITS = NGRP * BPG;
    localparam int unsigned WDOG_LIMIT = 20000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [11:0] i_cfg_index;
    logic [11:0] i_cfg_wdata;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in_item    i_in;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out_item   o_out;

    grouped_bitmap_block_allocator i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    // allocator model state
    logic             used_map [NBITS];
    logic [GCNT_W-1:0] grp_free [NGRP];
    logic [BLK_W-1:0]  vol_free;
    logic             m_first;
    logic [BLK_W-1:0]  m_count;
    logic [3:0]        m_groups;

    t_out_item expected_results[$];
    int        fail_count;
    int        send_idle_pct;
    int        recv_idle_pct;
    int        hold_off_cycles;
    int        quiet_cycles;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // model of one request
    function automatic t_out_item allocate_or_free(t_in_item req);
        t_out_item   r;
        int unsigned ng, g, goal, idx;
        bit          found;
        r = '0;
        found = 0;
        ng = (m_groups > NGRP) ? NGRP : m_groups;
        if (req.func == FUNC_ALLOC) begin
            goal = req.block_number;
            if (goal < m_first || goal >= m_count)
                goal = m_first;
            g = (goal - m_first) / BPG;
            r.status = ST_NO_SPACE;
            for (int i = 0; i < ng && !found; i++) begin
                if (g >= ng)
                    g = 0;
                if (grp_free[g] != 0) begin
                    for (int b = 0; b < BPG && !found; b++) begin
                        idx = g * BPG + b;
                        if (!used_map[idx]) begin
                            used_map[idx] = 1'b1;
                            grp_free[g] = grp_free[g] - 1;
                            if (vol_free != 0)
                                vol_free = vol_free - 1;
                            r.status = ST_OK;
                            r.result_block = BLK_W'(m_first + idx);
                            found = 1;
                        end
                    end
                end
                g++;
            end
        end else begin
            goal = req.block_number;
            if (goal < m_first || goal >= m_count || ng == 0 ||
                (goal - m_first) / BPG >= ng) begin
                r.status = ST_BAD_FREE;
            end else begin
                idx = goal - m_first;
                used_map[idx] = 1'b0;
                g = idx / BPG;
                if (grp_free[g] != GCNT_MAX)
                    grp_free[g] = grp_free[g] + 1;
                if (vol_free != TOTAL_MAX)
                    vol_free = vol_free + 1;
                r.status = ST_OK;
            end
        end
        r.free_total = vol_free;
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        fail_count++;
    endtask

    // one item on the request channel; valid drops only when the sender idles
    task automatic send_request(logic func, logic [BLK_W-1:0] blk);
        t_in_item req;
        req.func = func;
        req.block_number = blk;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in <= req;
        expected_results.push_back(allocate_or_free(req));
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_register(logic [1:0] idx, logic [11:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= 12'(idx);
        i_cfg_wdata <= val;
        @(posedge i_clk);
        case (idx)
            CFG_FIRST_DATA: m_first = val[0];
            CFG_BLOCKS_CNT: m_count = val;
            CFG_GROUPS_USE: m_groups = val[3:0];
            default: ;
        endcase
    endtask

    task automatic set_volume(logic first, logic [11:0] cnt, logic [11:0] grps);
        wait_drained();
        write_register(CFG_FIRST_DATA, 12'(first));
        write_register(CFG_BLOCKS_CNT, cnt);
        write_register(CFG_GROUPS_USE, grps);
        i_cfg_we <= 1'b0;
    endtask

    // random mix; allocations lean on goals in range
    task automatic random_requests(int n);
        logic [BLK_W-1:0] blk;
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(9))
                0:       blk = BLK_W'($urandom);
                1, 2:    blk = BLK_W'(m_first + $urandom_range(NBITS - 1) % 512);
                default: blk = BLK_W'(m_first + $urandom_range(NBITS - 1));
            endcase
            send_request(($urandom_range(99) < 45) ? FUNC_FREE : FUNC_ALLOC, blk);
        end
    endtask

    task automatic test_directed();
        send_request(FUNC_ALLOC, 12'd0);
        send_request(FUNC_ALLOC, 12'hFFF);
        send_request(FUNC_ALLOC, 12'd2048);
        send_request(FUNC_ALLOC, 12'd1500);
        send_request(FUNC_FREE, 12'd1);
        send_request(FUNC_FREE, 12'd1);
        send_request(FUNC_FREE, 12'd0);
        send_request(FUNC_FREE, 12'd2049);
        send_request(FUNC_FREE, 12'hFFF);
        send_request(FUNC_FREE, 12'd2048);
        send_request(FUNC_FREE, 12'hAAA);
        send_request(FUNC_FREE, 12'h555);
        // goal group beyond groups in use
        set_volume(1'b0, 12'd2049, 12'd2);
        send_request(FUNC_ALLOC, 12'd1800);
        send_request(FUNC_FREE, 12'd1800);
        // too many groups, then zero groups
        set_volume(1'b1, 12'hFFF, 12'd15);
        send_request(FUNC_ALLOC, 12'd4000);
        set_volume(1'b0, 12'd1, 12'd0);
        send_request(FUNC_ALLOC, 12'd0);
        send_request(FUNC_FREE, 12'd0);
    endtask

    // one small group filled to no space, then partly freed
    task automatic test_exhaustion();
        set_volume(1'b1, 12'd300, 12'd1);
        for (int k = 0; k < BPG + 4; k++)
            send_request(FUNC_ALLOC, BLK_W'($urandom));
        for (int k = 0; k < 40; k++)
            send_request(FUNC_FREE, BLK_W'(1 + $urandom_range(BPG - 1)));
        random_requests(40);
    endtask

    // receiver holds off while requests keep coming
    task automatic test_back_pressure();
        hold_off_cycles = 300;
        random_requests(12);
        wait_drained();
    endtask

    task automatic test_random();
        set_volume(1'b0, 12'd2048, 12'd8);
        send_idle_pct = 35;
        recv_idle_pct = 67;
        random_requests(250);
        set_volume(1'b1, 12'd1000, 12'd5);
        send_idle_pct = 67;
        recv_idle_pct = 35;
        random_requests(250);
        set_volume(1'b1, 12'd2049, 12'd8);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_requests(250);
    endtask

    // receiver idling and hold-off
    always @(posedge i_clk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // result checking
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result item", 1, 0);
            end else begin
                want = expected_results.pop_front();
                if (o_out.status != want.status)
                    report_mismatch("status", o_out.status, want.status);
                if (o_out.result_block != want.result_block)
                    report_mismatch("result_block", o_out.result_block, want.result_block);
                if (o_out.free_total != want.free_total)
                    report_mismatch("free_total", o_out.free_total, want.free_total);
            end
        end
    end

    // watchdog on progress
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        fail_count = 0;
        quiet_cycles = 0;
        hold_off_cycles = 0;
        send_idle_pct = 35;
        recv_idle_pct = 67;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_wdata = '0;
        i_in_valid = 1'b0;
        i_in = '0;
        i_out_ready = 1'b0;
        foreach (used_map[i])
            used_map[i] = 1'b0;
        foreach (grp_free[g])
            grp_free[g] = GCNT_W'(BPG);
        vol_free = BLK_W'(NBITS);
        m_first = 1'b1;
        m_count = 12'd2049;
        m_groups = 4'd8;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_exhaustion();
        test_back_pressure();
        test_random();
        wait_drained();
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
